/* hw/rtl/sscs_pkg.sv */
package sscs_pkg;

   localparam int PERIOD_WIDTH_DEFAULT = 10;
   localparam int NUM_SWEEPS = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;

   localparam int CUT_WIDTH = 12;
   localparam int INCL_WIDTH = 6;
   localparam int TEMP_WIDTH = 8;
   localparam int PIECE_WIDTH = 7;

   localparam logic [CUT_WIDTH-1:0]   CUT_LOW    = 12'd2000;
   localparam logic [CUT_WIDTH-1:0]   CUT_HIGH   = 12'd4000;
   localparam logic [CUT_WIDTH-1:0]   CUT_STEP   = 12'd100;
   localparam logic [INCL_WIDTH-1:0]  INCL_LOW   = 6'd14;
   localparam logic [INCL_WIDTH-1:0]  INCL_HIGH  = 6'd32;
   localparam logic [INCL_WIDTH-1:0]  INCL_STEP  = 6'd2;
   localparam logic [PIECE_WIDTH-1:0] PIECE_WRAP = 7'd99;
   localparam logic [TEMP_WIDTH-1:0]  TEMP_LOW_DEFAULT  = 8'd10;
   localparam logic [TEMP_WIDTH-1:0]  TEMP_HIGH_DEFAULT = 8'd40;
   localparam int PERIOD_RESET = 100;

   // sweep indexes into the prescaler arrays
   localparam int SWEEP_VERT  = 0;
   localparam int SWEEP_HORIZ = 1;
   localparam int SWEEP_INCL  = 2;

   typedef enum logic [2:0] {
      CSR_VERT_PERIOD  = 3'd0,
      CSR_HORIZ_PERIOD = 3'd1,
      CSR_INCL_PERIOD  = 3'd2,
      CSR_TEMP_LOW     = 3'd3,
      CSR_TEMP_HIGH    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CUT_WIDTH-1:0] duty;
      logic                 returning;
      logic                 done;
   } cut_sweep_type;

   typedef struct packed {
      logic [INCL_WIDTH-1:0] duty;
      logic                  returning;
   } incl_sweep_type;

   // one step of a cut sweep; rise_first selects the vertical shape
   function automatic cut_sweep_type cut_step(cut_sweep_type s, logic rise_first);
      cut_sweep_type r;
      r = s;
      if (!s.done) begin
         if (!s.returning) begin
            if (rise_first && (s.duty < CUT_HIGH)) begin
               r.duty = s.duty + CUT_STEP;
               if (r.duty == CUT_HIGH) r.returning = 1'b1;
            end else if (!rise_first && (s.duty > CUT_LOW)) begin
               r.duty = s.duty - CUT_STEP;
               if (r.duty == CUT_LOW) r.returning = 1'b1;
            end
         end else if (rise_first) begin
            r.duty = s.duty - CUT_STEP;
            if (r.duty == CUT_LOW) begin
               r.done = 1'b1;
               r.returning = 1'b0;
            end
         end else begin
            r.duty = s.duty + CUT_STEP;
            if (r.duty == CUT_HIGH) begin
               r.done = 1'b1;
               r.returning = 1'b0;
            end
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/servo_sweep_cut_sequencer.sv */
// Latency: a result is valid the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; the single result register is the
// only buffer, so the input stalls while a held result is itself stalled.
// Reset (synchronous, active high): sweeps home, flags and piece count
// cleared, periods 100, temperature limits 10 and 40, no result pending.
module servo_sweep_cut_sequencer
   import sscs_pkg::*;
#(
   parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_stop_toggle,
   input  logic                        req_tilt_event,
   input  logic                        req_presence_active,
   input  logic                        req_temp_update,
   input  logic [TEMP_WIDTH-1:0]       req_temp_reading,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [CUT_WIDTH-1:0]        rsp_vertical_duty,
   output logic [CUT_WIDTH-1:0]        rsp_horizontal_duty,
   output logic [INCL_WIDTH-1:0]       rsp_inclination_duty,
   output logic [PIECE_WIDTH-1:0]      rsp_piece_count,
   output logic                        rsp_production_running,
   output logic                        rsp_out_of_axis,
   output logic                        rsp_temp_alarm,

   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [CSR_DATA_WIDTH-1:0]   prdata,
   output logic                        pready
);

   logic [PERIOD_WIDTH-1:0] period_ff [NUM_SWEEPS];
   logic [PERIOD_WIDTH-1:0] period_in [NUM_SWEEPS];
   logic [PERIOD_WIDTH-1:0] tick_ff   [NUM_SWEEPS];
   logic [PERIOD_WIDTH-1:0] tick_in   [NUM_SWEEPS];
   logic                    hit       [NUM_SWEEPS];
   logic [PERIOD_WIDTH-1:0] tick_next;

   logic [TEMP_WIDTH-1:0]   temp_low_ff, temp_low_in;
   logic [TEMP_WIDTH-1:0]   temp_high_ff, temp_high_in;

   cut_sweep_type           vert_ff, vert_in, horiz_ff, horiz_in;
   incl_sweep_type          incl_ff, incl_in;
   logic                    stop_latch_ff, stop_latch_in;
   logic                    axis_fault_ff, axis_fault_in;
   logic                    temp_critical_ff, temp_critical_in;
   logic [PIECE_WIDTH-1:0]  pieces_ff, pieces_in;
   logic [PIECE_WIDTH-1:0]  pieces_inc;
   logic                    run_pre;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CUT_WIDTH-1:0]    rsp_vert_ff, rsp_horiz_ff;
   logic [INCL_WIDTH-1:0]   rsp_incl_ff;
   logic [PIECE_WIDTH-1:0]  rsp_pieces_ff;
   logic                    rsp_running_ff, rsp_running_in;
   logic                    rsp_axis_ff, rsp_alarm_ff;

   logic                    accept;
   logic                    csr_write;
   csr_index_type           csr_index;

   assign pready    = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         CSR_VERT_PERIOD:  prdata = CSR_DATA_WIDTH'(period_ff[SWEEP_VERT]);
         CSR_HORIZ_PERIOD: prdata = CSR_DATA_WIDTH'(period_ff[SWEEP_HORIZ]);
         CSR_INCL_PERIOD:  prdata = CSR_DATA_WIDTH'(period_ff[SWEEP_INCL]);
         CSR_TEMP_LOW:     prdata = CSR_DATA_WIDTH'(temp_low_ff);
         CSR_TEMP_HIGH:    prdata = CSR_DATA_WIDTH'(temp_high_ff);
         default:          prdata = '0;
      endcase
   end

   // next-state logic: prescaler ticks, sweeps, status flags, piece count and CSR writes
   always_comb begin
      period_in        = period_ff;
      temp_low_in      = temp_low_ff;
      temp_high_in     = temp_high_ff;
      tick_in          = tick_ff;
      vert_in          = vert_ff;
      horiz_in         = horiz_ff;
      incl_in          = incl_ff;
      stop_latch_in    = stop_latch_ff;
      axis_fault_in    = axis_fault_ff;
      temp_critical_in = temp_critical_ff;
      pieces_in        = pieces_ff;
      pieces_inc       = pieces_ff + 1'b1;
      run_pre          = 1'b0;
      rsp_running_in   = 1'b0;
      tick_next        = '0;

      for (int i = 0; i < NUM_SWEEPS; i++) begin
         tick_next = tick_ff[i] + 1'b1;
         hit[i]    = (tick_next >= period_ff[i]);
      end

      if (accept) begin
         stop_latch_in = stop_latch_ff ^ req_stop_toggle;
         axis_fault_in = axis_fault_ff | req_tilt_event;
         if (req_temp_update) begin
            temp_critical_in = (req_temp_reading < temp_low_ff) ||
                               (req_temp_reading > temp_high_ff);
         end
         run_pre = ~stop_latch_in & ~axis_fault_in & ~req_presence_active &
                   ~temp_critical_in;

         for (int i = 0; i < NUM_SWEEPS; i++) begin
            tick_next  = tick_ff[i] + 1'b1;
            tick_in[i] = hit[i] ? '0 : tick_next;
         end

         if (hit[SWEEP_VERT] && run_pre)  vert_in  = cut_step(vert_ff, 1'b1);
         if (hit[SWEEP_HORIZ] && run_pre) horiz_in = cut_step(horiz_ff, 1'b0);

         if (hit[SWEEP_INCL] && axis_fault_in) begin
            if (!incl_ff.returning && (incl_ff.duty > INCL_LOW)) begin
               incl_in.duty = incl_ff.duty - INCL_STEP;
               if (incl_in.duty == INCL_LOW) incl_in.returning = 1'b1;
            end else if (incl_ff.returning) begin
               incl_in.duty = incl_ff.duty + INCL_STEP;
               if (incl_in.duty == INCL_HIGH) begin
                  incl_in.returning = 1'b0;
                  axis_fault_in     = 1'b0;
               end
            end
         end

         if (vert_in.done && horiz_in.done) begin
            pieces_in      = (pieces_inc == PIECE_WRAP) ? '0 : pieces_inc;
            vert_in.done   = 1'b0;
            horiz_in.done  = 1'b0;
         end

         rsp_running_in = ~stop_latch_in & ~axis_fault_in & ~req_presence_active &
                          ~temp_critical_in;
      end

      // writing a period clears its prescaler
      if (csr_write) begin
         unique case (csr_index)
            CSR_VERT_PERIOD: begin
               period_in[SWEEP_VERT] = pwdata[PERIOD_WIDTH-1:0];
               tick_in[SWEEP_VERT]   = '0;
            end
            CSR_HORIZ_PERIOD: begin
               period_in[SWEEP_HORIZ] = pwdata[PERIOD_WIDTH-1:0];
               tick_in[SWEEP_HORIZ]   = '0;
            end
            CSR_INCL_PERIOD: begin
               period_in[SWEEP_INCL] = pwdata[PERIOD_WIDTH-1:0];
               tick_in[SWEEP_INCL]   = '0;
            end
            CSR_TEMP_LOW:  temp_low_in  = pwdata[TEMP_WIDTH-1:0];
            CSR_TEMP_HIGH: temp_high_in = pwdata[TEMP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SWEEPS; i++) begin
            period_ff[i] <= PERIOD_WIDTH'(PERIOD_RESET);
            tick_ff[i]   <= '0;
         end
         temp_low_ff      <= TEMP_LOW_DEFAULT;
         temp_high_ff     <= TEMP_HIGH_DEFAULT;
         vert_ff          <= '{duty: CUT_LOW, returning: 1'b0, done: 1'b0};
         horiz_ff         <= '{duty: CUT_HIGH, returning: 1'b0, done: 1'b0};
         incl_ff          <= '{duty: INCL_HIGH, returning: 1'b0};
         stop_latch_ff    <= 1'b0;
         axis_fault_ff    <= 1'b0;
         temp_critical_ff <= 1'b0;
         pieces_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         period_ff        <= period_in;
         tick_ff          <= tick_in;
         temp_low_ff      <= temp_low_in;
         temp_high_ff     <= temp_high_in;
         vert_ff          <= vert_in;
         horiz_ff         <= horiz_in;
         incl_ff          <= incl_in;
         stop_latch_ff    <= stop_latch_in;
         axis_fault_ff    <= axis_fault_in;
         temp_critical_ff <= temp_critical_in;
         pieces_ff        <= pieces_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_vert_ff    <= vert_in.duty;
         rsp_horiz_ff   <= horiz_in.duty;
         rsp_incl_ff    <= incl_in.duty;
         rsp_pieces_ff  <= pieces_in;
         rsp_running_ff <= rsp_running_in;
         rsp_axis_ff    <= axis_fault_in;
         rsp_alarm_ff   <= temp_critical_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_vertical_duty      = rsp_vert_ff;
   assign rsp_horizontal_duty    = rsp_horiz_ff;
   assign rsp_inclination_duty   = rsp_incl_ff;
   assign rsp_piece_count        = rsp_pieces_ff;
   assign rsp_production_running = rsp_running_ff;
   assign rsp_out_of_axis        = rsp_axis_ff;
   assign rsp_temp_alarm         = rsp_alarm_ff;

`ifndef ASSERT_OFF
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

   a_pieces_range: assert property (@(posedge clock) disable iff (reset)
      pieces_ff < PIECE_WRAP)
      else $error("piece count out of range");

   a_incl_return_needs_fault: assert property (@(posedge clock) disable iff (reset)
      incl_ff.returning |-> axis_fault_ff)
      else $error("inclination returning without axis fault");

   a_cut_range: assert property (@(posedge clock) disable iff (reset)
      (vert_ff.duty >= CUT_LOW) && (vert_ff.duty <= CUT_HIGH) &&
      (horiz_ff.duty >= CUT_LOW) && (horiz_ff.duty <= CUT_HIGH))
      else $error("cut duty out of range");
`endif

endmodule
